@@ rtl/ksavs_pkg.sv @@
// Shared types and constants for the key slot allocator with value store.
// No dependencies; imported by the channel interfaces and the top level.

package ksavs_pkg;

    localparam int unsigned KEY_W      = 8;
    localparam int unsigned VALUE_W    = 32;
    // Busy marks are searched in rows of this many slots
    localparam int unsigned GROUP_SIZE = 16;
    localparam int unsigned GIDX_W     = 4;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        ACT_CREATE = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SET    = 2'd2,
        ACT_GET    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOFREE  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

@@ rtl/ksavs_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on ksavs_pkg for payload types.

interface ksavs_req_if import ksavs_pkg::*; ();
    logic    valid;
    logic    ready;
    action_t action;
    key_t    key;
    value_t  value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface ksavs_rsp_if import ksavs_pkg::*; ();
    logic    valid;
    logic    ready;
    status_t status;
    key_t    key_out;
    value_t  value_out;

    modport source (output valid, output status, output key_out, output value_out,
                    input ready);
    modport sink   (input valid, input status, input key_out, input value_out,
                    output ready);
endinterface

@@ rtl/key_slot_allocator_value_store.sv @@
// Top level: lowest-free slot allocator with a per-slot 32-bit value store.
// Depends on ksavs_pkg and the channel interfaces in ksavs_if.sv.
//
//   channel | dir | payload                          | transaction when
//   --------+-----+----------------------------------+-------------------------
//   req     | in  | action, key, value               | req.valid & req.ready
//   rsp     | out | status, key_out, value_out       | rsp.valid & rsp.ready
//
// Each transaction has an accept step, which reads the value memory and picks
// the first row of busy marks with a free slot, and an execute step (S_EXEC),
// which searches that row, checks the key and writes marks, hint and memory back.
// Requests are taken one at a time; req.ready is high while no request is in work.
// A held rsp stalls the write-back cycle until the output register frees up.
// Reset clears busy marks and written bits at once; no clearing pass is needed.

module key_slot_allocator_value_store
    import ksavs_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    ksavs_req_if.sink   req,
    ksavs_rsp_if.source rsp
);

    localparam int unsigned KEY_IDX_W  = $clog2(SLOT_COUNT);
    localparam int unsigned HINT_W     = $clog2(SLOT_COUNT + 1);
    localparam int unsigned NUM_GROUPS = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int unsigned PAD_COUNT  = NUM_GROUPS * GROUP_SIZE;
    localparam int unsigned GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int unsigned SLOT_W     = GRP_W + GIDX_W;

    // Control state
    state_t                  state_reg, state_next;
    logic [SLOT_COUNT-1:0]   busy_reg;
    logic [SLOT_COUNT-1:0]   written_reg;
    logic [HINT_W-1:0]       hint_reg;

    // Request capture and first-stage search results
    action_t                 act_reg;
    key_t                    key_reg;
    value_t                  val_reg;
    value_t                  rd_data_reg;
    logic                    rd_written_reg;
    logic [GRP_W-1:0]        grp_reg;
    logic                    grp_found_reg;
    logic [GROUP_SIZE-1:0]   row_reg;

    // Output register
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    key_t                    out_key_reg;
    value_t                  out_value_reg;

    // Value store
    value_t                  mem [SLOT_COUNT];

    logic                    accept;
    logic                    exec_fire;
    logic [PAD_COUNT-1:0]    busy_pad;
    logic [PAD_COUNT-1:0]    free_pad;
    logic [NUM_GROUPS-1:0]   group_free;
    logic [GRP_W-1:0]        grp_sel;
    logic [GROUP_SIZE-1:0]   row_sel;
    logic [GIDX_W-1:0]       row_idx;
    logic [SLOT_W-1:0]       slot;
    logic [KEY_IDX_W-1:0]    slot_kidx;
    logic [KEY_IDX_W-1:0]    key_kidx;
    logic                    key_in_range;
    logic                    key_live;
    value_t                  rd_val;
    status_t                 res_status;
    key_t                    res_key;
    value_t                  res_value;
    logic                    grant;
    logic                    do_delete;
    logic                    mem_we;

    assign accept = req.valid && req.ready;

    // Stage 1: free marks at or above the hint, then first row holding a free slot
    always_comb
    begin
        busy_pad                   = '1;
        busy_pad[SLOT_COUNT-1:0]   = busy_reg;
        for (int i = 0; i < PAD_COUNT; i++)
        begin
            free_pad[i] = !busy_pad[i] && (9'(i) >= 9'(hint_reg));
        end
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_free[g] = |free_pad[g*GROUP_SIZE +: GROUP_SIZE];
        end
        grp_sel = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (group_free[g])
            begin
                grp_sel = GRP_W'(g);
            end
        end
        row_sel = free_pad[grp_sel*GROUP_SIZE +: GROUP_SIZE];
    end

    // Stage 2: lowest free slot inside the chosen row
    always_comb
    begin
        row_idx = '0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (row_reg[i])
            begin
                row_idx = GIDX_W'(i);
            end
        end
        slot      = {grp_reg, row_idx};
        slot_kidx = slot[KEY_IDX_W-1:0];
    end

    // Key check and result
    always_comb
    begin
        key_kidx     = key_reg[KEY_IDX_W-1:0];
        key_in_range = ({1'b0, key_reg} < 9'(SLOT_COUNT));
        key_live     = key_in_range && busy_reg[key_kidx];
        rd_val       = rd_written_reg ? rd_data_reg : '0;
        res_status   = ST_OK;
        res_key      = '0;
        res_value    = '0;
        grant        = 1'b0;
        do_delete    = 1'b0;
        mem_we       = 1'b0;
        case (act_reg)
            ACT_CREATE:
            begin
                if (grp_found_reg)
                begin
                    res_key = KEY_W'(slot);
                    grant   = exec_fire;
                end
                else
                begin
                    res_status = ST_NOFREE;
                end
            end
            default:
            begin
                if (!key_live)
                begin
                    res_status = ST_INVALID;
                end
                else if (act_reg == ACT_DELETE)
                begin
                    do_delete = exec_fire;
                end
                else if (act_reg == ACT_SET)
                begin
                    mem_we = exec_fire;
                end
                else
                begin
                    res_value = rd_val;
                end
            end
        endcase
    end

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req.ready = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            S_IDLE: req.ready = 1'b1;
            S_EXEC: exec_fire = !out_valid_reg || rsp.ready;
            default:
            begin
                req.ready = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            written_reg   <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (grant)
            begin
                busy_reg[slot_kidx] <= 1'b1;
                hint_reg            <= HINT_W'(slot) + HINT_W'(1);
            end
            if (do_delete)
            begin
                busy_reg[key_kidx] <= 1'b0;
                if ({1'b0, key_reg} < 9'(hint_reg))
                begin
                    hint_reg <= HINT_W'(key_reg);
                end
            end
            if (mem_we)
            begin
                written_reg[key_kidx] <= 1'b1;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and stage-1 pipeline registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg        <= req.action;
            key_reg        <= req.key;
            val_reg        <= req.value;
            rd_written_reg <= written_reg[req.key[KEY_IDX_W-1:0]];
            grp_reg        <= grp_sel;
            grp_found_reg  <= |group_free;
            row_reg        <= row_sel;
        end
    end

    // Value memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[key_kidx] <= val_reg;
        end
        if (accept)
        begin
            rd_data_reg <= mem[req.key[KEY_IDX_W-1:0]];
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_status_reg <= res_status;
            out_key_reg    <= res_key;
            out_value_reg  <= res_value;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.key_out   = out_key_reg;
    assign rsp.value_out = out_value_reg;

    // Checks
    a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
        9'(hint_reg) <= 9'(SLOT_COUNT))
        else $error("search hint beyond slot count");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_EXEC)
        else $error("response raised without an executing request");

    a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        grant |=> busy_reg[$past(slot_kidx)])
        else $error("granted slot not marked busy");

    a_delete_frees: assert property (@(posedge clk) disable iff (!rst_n)
        do_delete |=> !busy_reg[$past(key_kidx)]
                      && (9'(hint_reg) <= 9'($past(key_kidx))))
        else $error("deleted slot still busy or hint above it");

endmodule
